>>> rtl/two_level_lru_cache_tag_model_defines.svh
// Assertion macros for the two-level LRU cache tag model.
// Included by the top level; no other dependencies.
`ifndef TWO_LEVEL_LRU_CACHE_TAG_MODEL_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_TAG_MODEL_DEFINES_SVH
// Asserts that an implication holds at every clock edge outside reset.
`define TLC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Asserts that a condition holds in the cycle after an antecedent.
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/tlc_pkg.sv
// Package for the two-level LRU cache tag model: sizes, status codes, register indexes,
// states and the payload structs. It depends on nothing else.
package tlc_pkg;
  localparam int L1_MAX_WAYS = 8;
  localparam int L1_MAX_SETS = 256;
  localparam int L2_MAX_WAYS = 16;
  localparam int L2_MAX_SETS = 1024;

  typedef enum logic [2:0] {
    ST_NONE  = 3'd0,
    ST_RHIT  = 3'd1,
    ST_RMISS = 3'd2,
    ST_WHIT  = 3'd3,
    ST_WMISS = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_L1_OFFSET = 3'd0,
    REG_L1_INDEX  = 3'd1,
    REG_L1_WAYS   = 3'd2,
    REG_L2_OFFSET = 3'd3,
    REG_L2_INDEX  = 3'd4,
    REG_L2_WAYS   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic [2:0] l1_status;
    logic [2:0] l2_status;
  } out_item_t;
endpackage

>>> rtl/two_level_lru_cache_tag_model.sv
// Top level of the two-level LRU cache tag model: tag, valid and age memories
// with a read-modify-write sequencer. Depends on tlc_pkg and the defines header.
//
// Channel   Direction  Signals
// command   in         start, busy, item
// result    out        done, result
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// After the accepting edge an access goes through S_READ, a set read from the memories,
// then S_UPDATE, compare and write-back with the result strobe on done. Busy stays high
// through both, so the next start is taken in the cycle after the strobe.
// After reset a clearing pass walks every L1 and L2 set and clears valid bits and ages,
// with busy high.
// Results carry a one-cycle strobe on done; the receiver cannot stall.
`include "two_level_lru_cache_tag_model_defines.svh"
module two_level_lru_cache_tag_model #(
  parameter int L1_MAX_WAYS = tlc_pkg::L1_MAX_WAYS,
  parameter int L1_MAX_SETS = tlc_pkg::L1_MAX_SETS,
  parameter int L2_MAX_WAYS = tlc_pkg::L2_MAX_WAYS,
  parameter int L2_MAX_SETS = tlc_pkg::L2_MAX_SETS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tlc_pkg::in_item_t  item,
  output logic               done,
  output tlc_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  localparam int S1W = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int S2W = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int A1W = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
  localparam int A2W = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
  localparam int W1W = $clog2(L1_MAX_WAYS + 1);
  localparam int W2W = $clog2(L2_MAX_WAYS + 1);
  localparam int CLRN = (L1_MAX_SETS > L2_MAX_SETS) ? L1_MAX_SETS : L2_MAX_SETS;
  localparam int CW = $clog2(CLRN + 1);

  typedef logic [L1_MAX_WAYS-1:0][31:0]  tag1_row_t;
  typedef logic [L1_MAX_WAYS-1:0][A1W:0] meta1_row_t;
  typedef logic [L2_MAX_WAYS-1:0][31:0]  tag2_row_t;
  typedef logic [L2_MAX_WAYS-1:0][A2W:0] meta2_row_t;

  tag1_row_t  tag1_mem  [L1_MAX_SETS];
  meta1_row_t meta1_mem [L1_MAX_SETS];
  tag2_row_t  tag2_mem  [L2_MAX_SETS];
  meta2_row_t meta2_mem [L2_MAX_SETS];

  tag1_row_t  tag1_q;
  meta1_row_t meta1_q;
  tag2_row_t  tag2_q;
  meta2_row_t meta2_q;

  logic [4:0] l1_offset_bits, l2_offset_bits;
  logic [3:0] l1_index_bits, l2_index_bits;
  logic [3:0] l1_ways;
  logic [4:0] l2_ways;

  tlc_pkg::state_t state, state_next;
  logic [CW-1:0] clr_cnt;
  logic          act;
  logic [S1W-1:0] set1, set1_c;
  logic [S2W-1:0] set2, set2_c;
  logic [31:0]    tag1, tag1_c, tag2, tag2_c;
  logic [W1W-1:0] w1;
  logic [W2W-1:0] w2;

  function automatic logic [4:0] fit_bits(input logic [3:0] ib, input int max_sets);
    logic [4:0] b;
    b = {1'b0, ib};
    for (int k = 15; k >= 1; k--) begin
      if (b == 5'(k) && (longint'(1) << k) > longint'(max_sets)) begin
        b = 5'(k - 1);
      end
    end
    return b;
  endfunction

  logic [4:0]  b1, b2;
  logic [5:0]  sh1, sh2;
  logic [31:0] off1v, off2v;

  always_comb begin
    b1 = fit_bits(l1_index_bits, L1_MAX_SETS);
    b2 = fit_bits(l2_index_bits, L2_MAX_SETS);
    off1v = item.address >> l1_offset_bits;
    off2v = item.address >> l2_offset_bits;
    set1_c = S1W'(off1v & ((32'd1 << b1) - 32'd1));
    set2_c = S2W'(off2v & ((32'd1 << b2) - 32'd1));
    sh1 = 6'(l1_offset_bits) + 6'(b1);
    sh2 = 6'(l2_offset_bits) + 6'(b2);
    tag1_c = (sh1 < 6'd32) ? (item.address >> sh1) : 32'd0;
    tag2_c = (sh2 < 6'd32) ? (item.address >> sh2) : 32'd0;
  end

  always_comb begin
    if (l1_ways == 4'd0) begin
      w1 = W1W'(1);
    end else if (32'(l1_ways) > 32'(L1_MAX_WAYS)) begin
      w1 = W1W'(L1_MAX_WAYS);
    end else begin
      w1 = W1W'(l1_ways);
    end
    if (l2_ways == 5'd0) begin
      w2 = W2W'(1);
    end else if (32'(l2_ways) > 32'(L2_MAX_WAYS)) begin
      w2 = W2W'(L2_MAX_WAYS);
    end else begin
      w2 = W2W'(l2_ways);
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_offset_bits <= 5'd6;
      l1_index_bits  <= 4'd4;
      l1_ways        <= 4'd4;
      l2_offset_bits <= 5'd6;
      l2_index_bits  <= 4'd6;
      l2_ways        <= 5'd8;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlc_pkg::REG_L1_OFFSET: l1_offset_bits <= cfg_data[4:0];
        tlc_pkg::REG_L1_INDEX:  l1_index_bits  <= cfg_data[3:0];
        tlc_pkg::REG_L1_WAYS:   l1_ways        <= cfg_data[3:0];
        tlc_pkg::REG_L2_OFFSET: l2_offset_bits <= cfg_data[4:0];
        tlc_pkg::REG_L2_INDEX:  l2_index_bits  <= cfg_data[3:0];
        tlc_pkg::REG_L2_WAYS:   l2_ways        <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state)
      tlc_pkg::S_CLEAR:  state_next = (clr_cnt == CW'(CLRN - 1)) ? tlc_pkg::S_IDLE
                                                                 : tlc_pkg::S_CLEAR;
      tlc_pkg::S_IDLE:   state_next = start ? tlc_pkg::S_READ : tlc_pkg::S_IDLE;
      tlc_pkg::S_READ:   state_next = tlc_pkg::S_UPDATE;
      tlc_pkg::S_UPDATE: state_next = tlc_pkg::S_IDLE;
      default:           state_next = tlc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != tlc_pkg::S_IDLE);
    done = (state == tlc_pkg::S_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tlc_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == tlc_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act  <= item.action;
      set1 <= set1_c;
      set2 <= set2_c;
      tag1 <= tag1_c;
      tag2 <= tag2_c;
    end
  end

  // Metadata entries hold {valid, age}.
  logic [L1_MAX_WAYS-1:0] hv1;
  logic [L2_MAX_WAYS-1:0] hv2;
  logic                   hit1, hit2;
  logic [A1W-1:0]         hw1, vic1;
  logic [A2W-1:0]         hw2, vic2;
  meta1_row_t             touch1, fill1;
  meta2_row_t             touch2, fill2;
  logic                   wr1_meta, wr1_tag, wr2_meta, wr2_tag;
  meta1_row_t             meta1_wd;
  meta2_row_t             meta2_wd;
  tlc_pkg::status_t       s1, s2;

  always_comb begin
    for (int w = 0; w < L1_MAX_WAYS; w++) begin
      hv1[w] = (W1W'(w) < w1) && meta1_q[w][A1W] && (tag1_q[w] == tag1);
    end
    for (int w = 0; w < L2_MAX_WAYS; w++) begin
      hv2[w] = (W2W'(w) < w2) && meta2_q[w][A2W] && (tag2_q[w] == tag2);
    end
    hit1 = |hv1;
    hit2 = |hv2;
    hw1 = '0;
    for (int w = L1_MAX_WAYS - 1; w >= 0; w--) begin
      if (hv1[w]) hw1 = A1W'(w);
    end
    hw2 = '0;
    for (int w = L2_MAX_WAYS - 1; w >= 0; w--) begin
      if (hv2[w]) hw2 = A2W'(w);
    end
    vic1 = '0;
    for (int w = L1_MAX_WAYS - 1; w >= 0; w--) begin
      if ((W1W'(w) < w1) && meta1_q[w][A1W-1:0] == '0) vic1 = A1W'(w);
    end
    vic2 = '0;
    for (int w = L2_MAX_WAYS - 1; w >= 0; w--) begin
      if ((W2W'(w) < w2) && meta2_q[w][A2W-1:0] == '0) vic2 = A2W'(w);
    end
    touch1 = meta1_q;
    fill1  = meta1_q;
    for (int w = 0; w < L1_MAX_WAYS; w++) begin
      if (W1W'(w) < w1) begin
        if (A1W'(w) == hw1) begin
          touch1[w][A1W-1:0] = A1W'(w1 - W1W'(1));
        end else if (meta1_q[w][A1W-1:0] > meta1_q[hw1][A1W-1:0]) begin
          touch1[w][A1W-1:0] = meta1_q[w][A1W-1:0] - A1W'(1);
        end
        if (A1W'(w) == vic1) begin
          fill1[w] = {1'b1, A1W'(w1 - W1W'(1))};
        end else if (meta1_q[w][A1W-1:0] != '0) begin
          fill1[w][A1W-1:0] = meta1_q[w][A1W-1:0] - A1W'(1);
        end
      end
    end
    touch2 = meta2_q;
    fill2  = meta2_q;
    for (int w = 0; w < L2_MAX_WAYS; w++) begin
      if (W2W'(w) < w2) begin
        if (A2W'(w) == hw2) begin
          touch2[w][A2W-1:0] = A2W'(w2 - W2W'(1));
        end else if (meta2_q[w][A2W-1:0] > meta2_q[hw2][A2W-1:0]) begin
          touch2[w][A2W-1:0] = meta2_q[w][A2W-1:0] - A2W'(1);
        end
        if (A2W'(w) == vic2) begin
          fill2[w] = {1'b1, A2W'(w2 - W2W'(1))};
        end else if (meta2_q[w][A2W-1:0] != '0) begin
          fill2[w][A2W-1:0] = meta2_q[w][A2W-1:0] - A2W'(1);
        end
      end
    end

    wr1_meta = 1'b0;
    wr1_tag  = 1'b0;
    wr2_meta = 1'b0;
    wr2_tag  = 1'b0;
    meta1_wd = touch1;
    meta2_wd = touch2;
    if (act) begin
      s1 = hit1 ? tlc_pkg::ST_WHIT : tlc_pkg::ST_WMISS;
      s2 = hit2 ? tlc_pkg::ST_WHIT : tlc_pkg::ST_WMISS;
      wr1_meta = hit1;
      wr2_meta = hit2;
    end else if (hit1) begin
      s1 = tlc_pkg::ST_RHIT;
      s2 = tlc_pkg::ST_NONE;
      wr1_meta = 1'b1;
    end else begin
      s1 = tlc_pkg::ST_RMISS;
      wr1_meta = 1'b1;
      wr1_tag  = 1'b1;
      meta1_wd = fill1;
      wr2_meta = 1'b1;
      if (hit2) begin
        s2 = tlc_pkg::ST_RHIT;
      end else begin
        s2 = tlc_pkg::ST_RMISS;
        wr2_tag  = 1'b1;
        meta2_wd = fill2;
      end
    end
    result.l1_status = s1;
    result.l2_status = s2;
  end

  always_ff @(posedge clk) begin
    if (state == tlc_pkg::S_CLEAR) begin
      if (clr_cnt < CW'(L1_MAX_SETS)) meta1_mem[S1W'(clr_cnt)] <= '0;
      if (clr_cnt < CW'(L2_MAX_SETS)) meta2_mem[S2W'(clr_cnt)] <= '0;
    end else if (state == tlc_pkg::S_UPDATE) begin
      if (wr1_meta) meta1_mem[set1] <= meta1_wd;
      if (wr2_meta) meta2_mem[set2] <= meta2_wd;
      if (wr1_tag) tag1_mem[set1][vic1] <= tag1;
      if (wr2_tag) tag2_mem[set2][vic2] <= tag2;
    end
  end

  always_ff @(posedge clk) begin
    tag1_q  <= tag1_mem[set1];
    meta1_q <= meta1_mem[set1];
    tag2_q  <= tag2_mem[set2];
    meta2_q <= meta2_mem[set2];
  end

  `TLC_ASSERT_IMP(a_done_after_read, clk, rst, done, $past(state) == tlc_pkg::S_READ,
    "result strobe without a preceding set read")
  `TLC_ASSERT_NEXT(a_start_reads, clk, rst, start && !busy, state == tlc_pkg::S_READ,
    "accepted command did not start a set read")
  `TLC_ASSERT_IMP(a_l1_hit_no_l2, clk, rst, done && result.l1_status == tlc_pkg::ST_RHIT,
    result.l2_status == tlc_pkg::ST_NONE, "L2 reported on an L1 read hit")
endmodule

>>> tb/tb.sv
// Self-checking testbench for the two-level LRU cache tag model: directed and
// random read/write streams over several cache geometries, checked against
// an in-bench tag/valid/age predictor. Depends on tlc_pkg and the RTL top.
`timescale 1ns / 1ps
module tb;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int L1_DEPTH = tlc_pkg::L1_MAX_SETS * tlc_pkg::L1_MAX_WAYS;
  localparam int L2_DEPTH = tlc_pkg::L2_MAX_SETS * tlc_pkg::L2_MAX_WAYS;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  tlc_pkg::in_item_t  item = '0;
  logic               done;
  tlc_pkg::out_item_t result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  two_level_lru_cache_tag_model dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted geometry and arrays.
  logic [4:0]  p_l1_off = 5'd6;
  logic [3:0]  p_l1_ib = 4'd4;
  logic [3:0]  p_l1_ways = 4'd4;
  logic [4:0]  p_l2_off = 5'd6;
  logic [3:0]  p_l2_ib = 4'd6;
  logic [4:0]  p_l2_ways = 5'd8;
  logic [31:0] l1_tags [L1_DEPTH];
  logic        l1_vld [L1_DEPTH];
  logic [3:0]  l1_age [L1_DEPTH];
  logic [31:0] l2_tags [L2_DEPTH];
  logic        l2_vld [L2_DEPTH];
  logic [3:0]  l2_age [L2_DEPTH];

  tlc_pkg::out_item_t pending_status [$];
  int          errors = 0;
  int          mismatches = 0;
  logic [31:0] addr_pool [16];

  function automatic void split(input logic [31:0] addr, input logic [4:0] off,
                                input logic [3:0] ib, input int max_sets,
                                output int set, output logic [31:0] tag);
    int b;
    int sh;
    b = ib;
    while (b > 0 && (1 << b) > max_sets) b--;
    set = (off < 32) ? int'((addr >> off) & ((32'd1 << b) - 32'd1)) : 0;
    sh = off + b;
    tag = (sh < 32) ? (addr >> sh) : 32'd0;
  endfunction

  function automatic int lookup(input bit lvl, input int base, input int ways,
                                input logic [31:0] tag);
    for (int w = 0; w < ways; w++) begin
      if (lvl == 0 && l1_vld[base + w] && l1_tags[base + w] == tag) return w;
      if (lvl == 1 && l2_vld[base + w] && l2_tags[base + w] == tag) return w;
    end
    return -1;
  endfunction

  function automatic void age_on_hit(input bit lvl, input int base, input int ways,
                                     input int hit);
    logic [3:0] old;
    old = lvl ? l2_age[base + hit] : l1_age[base + hit];
    for (int w = 0; w < ways; w++) begin
      if (lvl == 0) begin
        if (w == hit) l1_age[base + w] = 4'(ways - 1);
        else if (l1_age[base + w] > old) l1_age[base + w]--;
      end else begin
        if (w == hit) l2_age[base + w] = 4'(ways - 1);
        else if (l2_age[base + w] > old) l2_age[base + w]--;
      end
    end
  endfunction

  function automatic void allocate(input bit lvl, input int base, input int ways,
                                   input logic [31:0] tag);
    int victim;
    victim = 0;
    for (int w = 0; w < ways; w++) begin
      if ((lvl ? l2_age[base + w] : l1_age[base + w]) == 0) begin
        victim = w;
        break;
      end
    end
    for (int w = 0; w < ways; w++) begin
      if (lvl == 0) begin
        if (w == victim) l1_age[base + w] = 4'(ways - 1);
        else if (l1_age[base + w] > 0) l1_age[base + w]--;
      end else begin
        if (w == victim) l2_age[base + w] = 4'(ways - 1);
        else if (l2_age[base + w] > 0) l2_age[base + w]--;
      end
    end
    if (lvl == 0) begin
      l1_tags[base + victim] = tag;
      l1_vld[base + victim] = 1'b1;
    end else begin
      l2_tags[base + victim] = tag;
      l2_vld[base + victim] = 1'b1;
    end
  endfunction

  function automatic tlc_pkg::out_item_t access_status(input tlc_pkg::in_item_t it);
    tlc_pkg::out_item_t r;
    int w1, w2, s1, s2, b1, b2, h1, h2;
    logic [31:0] t1, t2;
    w1 = (p_l1_ways < 1) ? 1 : (p_l1_ways > tlc_pkg::L1_MAX_WAYS) ? tlc_pkg::L1_MAX_WAYS
                                                                  : p_l1_ways;
    w2 = (p_l2_ways < 1) ? 1 : (p_l2_ways > tlc_pkg::L2_MAX_WAYS) ? tlc_pkg::L2_MAX_WAYS
                                                                  : p_l2_ways;
    split(it.address, p_l1_off, p_l1_ib, tlc_pkg::L1_MAX_SETS, s1, t1);
    split(it.address, p_l2_off, p_l2_ib, tlc_pkg::L2_MAX_SETS, s2, t2);
    b1 = s1 * tlc_pkg::L1_MAX_WAYS;
    b2 = s2 * tlc_pkg::L2_MAX_WAYS;
    h1 = lookup(0, b1, w1, t1);
    if (it.action) begin
      r.l1_status = tlc_pkg::ST_WMISS;
      r.l2_status = tlc_pkg::ST_WMISS;
      if (h1 >= 0) begin
        r.l1_status = tlc_pkg::ST_WHIT;
        age_on_hit(0, b1, w1, h1);
      end
      h2 = lookup(1, b2, w2, t2);
      if (h2 >= 0) begin
        r.l2_status = tlc_pkg::ST_WHIT;
        age_on_hit(1, b2, w2, h2);
      end
    end else if (h1 >= 0) begin
      r.l1_status = tlc_pkg::ST_RHIT;
      r.l2_status = tlc_pkg::ST_NONE;
      age_on_hit(0, b1, w1, h1);
    end else begin
      r.l1_status = tlc_pkg::ST_RMISS;
      h2 = lookup(1, b2, w2, t2);
      if (h2 >= 0) begin
        r.l2_status = tlc_pkg::ST_RHIT;
        age_on_hit(1, b2, w2, h2);
      end else begin
        r.l2_status = tlc_pkg::ST_RMISS;
        allocate(1, b2, w2, t2);
      end
      allocate(0, b1, w1, t1);
    end
    return r;
  endfunction

  // Leaves start high; the caller lowers it when a gap follows.
  task automatic send_access(input logic action, input logic [31:0] addr);
    tlc_pkg::in_item_t it;
    it.action = action;
    it.address = addr;
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_status.push_back(access_status(it));
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
    cfg_index <= idx;
    cfg_data <= ($urandom & 32'hFFFF_FFE0) | 32'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    unique case (idx)
      tlc_pkg::REG_L1_OFFSET: p_l1_off = value;
      tlc_pkg::REG_L1_INDEX:  p_l1_ib = value[3:0];
      tlc_pkg::REG_L1_WAYS:   p_l1_ways = value[3:0];
      tlc_pkg::REG_L2_OFFSET: p_l2_off = value;
      tlc_pkg::REG_L2_INDEX:  p_l2_ib = value[3:0];
      tlc_pkg::REG_L2_WAYS:   p_l2_ways = value;
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [4:0] o1, input logic [3:0] i1,
                              input logic [3:0] w1, input logic [4:0] o2,
                              input logic [3:0] i2, input logic [4:0] w2);
    drain();
    write_reg(tlc_pkg::REG_L1_OFFSET, o1);
    write_reg(tlc_pkg::REG_L1_INDEX, {1'b0, i1});
    write_reg(tlc_pkg::REG_L1_WAYS, {1'b0, w1});
    write_reg(tlc_pkg::REG_L2_OFFSET, o2);
    write_reg(tlc_pkg::REG_L2_INDEX, {1'b0, i2});
    write_reg(tlc_pkg::REG_L2_WAYS, w2);
  endtask

  task automatic test_directed;
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFFF);
    send_access(1'b1, 32'hFFFF_FFC0);
    idle_cycles(3);
    // Five tags in one L1 set with four ways push the first out of L1 only.
    for (int k = 0; k < 5; k++) send_access(1'b0, 32'h0001_0000 * k + 32'h40);
    send_access(1'b0, 32'h0000_0040);
    send_access(1'b1, 32'h0002_0040);
    send_access(1'b1, 32'h1234_5678);
    drain();
    // Reserved register indexes must change nothing.
    write_reg(REG_SPARE_LO, 5'd1);
    write_reg(REG_SPARE_HI, 5'd31);
    send_access(1'b0, 32'h0000_0040);
    send_access(1'b0, 32'h0003_0040);
    set_geometry(5'd31, 4'd15, 4'd0, 5'd31, 4'd15, 5'd0);
    send_access(1'b0, 32'hDEAD_BEEF);
    send_access(1'b0, 32'h0000_0001);
    send_access(1'b1, 32'h8000_0000);
    send_access(1'b0, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_phase(input int count);
    int sent;
    int burst;
    logic [31:0] a;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < count; k++) begin
        if ($urandom_range(0, 3) != 0)
          a = addr_pool[$urandom_range(0, 15)] ^ 32'($urandom_range(0, 63));
        else
          a = $urandom;
        send_access(1'($urandom_range(0, 3) == 0), a);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic test_geometries;
    set_geometry(5'd6, 4'd4, 4'd4, 5'd6, 4'd6, 5'd8);
    test_random_phase(310);
    set_geometry(5'd0, 4'd0, 4'd1, 5'd0, 4'd0, 5'd1);
    test_random_phase(310);
    set_geometry(5'd16, 4'd8, 4'd8, 5'd16, 4'd10, 5'd16);
    test_random_phase(310);
    set_geometry(5'd31, 4'd15, 4'd15, 5'd31, 4'd15, 5'd31);
    test_random_phase(150);
    for (int p = 0; p < 3; p++) begin
      set_geometry(5'($urandom_range(0, 8)), 4'($urandom_range(0, 3)),
                   4'($urandom_range(1, 4)), 5'($urandom_range(0, 8)),
                   4'($urandom_range(0, 4)), 5'($urandom_range(1, 6)));
      test_random_phase(260);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("Unexpected result %h", result);
      end else begin
        tlc_pkg::out_item_t e;
        e = pending_status.pop_front();
        if (result.l1_status !== e.l1_status || result.l2_status !== e.l2_status) begin
          errors++;
          if (mismatches++ < 10)
            $display("Mismatch: expected l1=%0d l2=%0d, got l1=%0d l2=%0d",
                     e.l1_status, e.l2_status, result.l1_status, result.l2_status);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < L1_DEPTH; i++) begin
      l1_tags[i] = '0;
      l1_vld[i] = 1'b0;
      l1_age[i] = '0;
    end
    for (int i = 0; i < L2_DEPTH; i++) begin
      l2_tags[i] = '0;
      l2_vld[i] = 1'b0;
      l2_age[i] = '0;
    end
    for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_geometries();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
